[rtl/core/ewt_pkg.sv]
// ----------------------------------------------------------------------------
// ewt_pkg: shared types and constants for the exponential time weighting
// Widths, register indexes, sequencer states and the control bundles that
// pass between the sequencer, the shared multiplier and the square root unit.
// ----------------------------------------------------------------------------
package ewt_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_FRAC_BITS = 32;
	localparam int MS_FRAC_BITS   = 16;
	localparam int MS_BITS        = 63;
	localparam int LEVEL_BITS     = 32;
	localparam int CFG_DATA_BITS  = 32;
	localparam int MODE_BITS      = 2;
	localparam int NUM_REGS       = 4;
	localparam int CFG_IDX_BITS   = $clog2(NUM_REGS);

	// Shared multiplier: signed 33 x 33, enough for a 32-bit half of the
	// difference plus its sign, and for the unsigned coefficient.
	localparam int MUL_OP_BITS = 33;
	localparam int PROD_BITS   = 2 * MUL_OP_BITS;
	localparam int ACC_BITS    = 64;
	localparam int HALF_BITS   = ACC_BITS / 2;
	localparam int SQ_BITS     = 2 * SAMPLE_BITS;

	// Square root unit: one result bit per step
	localparam int ROOT_BITS = LEVEL_BITS;
	localparam int RAD_BITS  = 2 * ROOT_BITS;
	localparam int REM_BITS  = ROOT_BITS + 2;
	localparam int STEP_BITS = $clog2(ROOT_BITS);

	localparam logic [COEF_FRAC_BITS-1:0] COEF_FAST_RST    = COEF_FRAC_BITS'(32'd4294251528);
	localparam logic [COEF_FRAC_BITS-1:0] COEF_SLOW_RST    = COEF_FRAC_BITS'(32'd4294877818);
	localparam logic [COEF_FRAC_BITS-1:0] COEF_IMPULSE_RST = COEF_FRAC_BITS'(32'd4292411529);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MODE,
		REG_COEF_FAST,
		REG_COEF_SLOW,
		REG_COEF_IMPULSE
	} reg_idx_t;

	typedef enum logic [MODE_BITS-1:0] {
		MODE_FAST    = 2'd0,
		MODE_SLOW    = 2'd1,
		MODE_IMPULSE = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		MUL_SQUARE,
		MUL_DIFF_LO,
		MUL_DIFF_HI
	} mul_sel_t;

	typedef struct packed {
		logic     en;
		mul_sel_t sel;
	} mul_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} root_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_DIFF,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ADD,
		ST_ROOT_GO,
		ST_ROOT,
		ST_OUT
	} state_t;

endpackage

[rtl/core/exponential_time_weighting.sv]
// in_ready is high only in the idle state, so a new request is taken only once the last
// level has been loaded into the output register. The work is the bit-serial square root
// (32 steps) and three passes through the shared multiplier (only the square when it seeds).
// The output register lets the next request in while a level waits.
// Reset (arst_n low, asynchronous): registers take their default coefficients and fast mode,
// the running mean square is cleared and the next sample seeds the average.
// ----------------------------------------------------------------------------
// exponential_time_weighting: time-weighted RMS level detector
// Squares each sample, smooths the square with a one-pole exponential
// average (fast, slow or impulse factor) and returns the floor square root
// of the running mean square.
// ----------------------------------------------------------------------------
module exponential_time_weighting
	import ewt_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration write channel
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	// sample channel
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                     restart,
	// level channel
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [LEVEL_BITS-1:0]    level
);

	// Smoothing identity used here:
	//   floor((a*y + (2^C - a)*v) / 2^C) = v + floor(a*(y - v) / 2^C)
	// The signed difference d = y - v is split into halves; with
	// p0 = a*d[31:0] (unsigned) and p1 = a*d[63:32] (signed) the new value is
	//   v + (p0 >> C) + (p1 << (32 - C)).

	state_t state_q;
	state_t state_n;

	logic [COEF_FRAC_BITS-1:0]   coef;
	logic [COEF_FRAC_BITS-1:0]   coef_q;
	logic [SAMPLE_BITS-1:0]      raw;
	logic [SAMPLE_BITS-1:0]      mag_c;
	logic [SAMPLE_BITS-1:0]      mag_q;
	logic                        seeded_q;
	logic                        seed_q;
	logic [MS_BITS-1:0]          y_q;
	logic [MS_BITS-1:0]          v_q;
	logic [MS_BITS-1:0]          v_c;
	logic [ACC_BITS-1:0]         diff_q;
	logic [ACC_BITS-1:0]         acc_q;
	logic [ACC_BITS-1:0]         hi_term;
	logic signed [PROD_BITS-1:0] prod_q;
	logic [LEVEL_BITS-1:0]       level_q;
	logic                        out_valid_q;

	mul_ctl_t         mul_ctl;
	root_stat_t       root_stat;
	logic             root_start;
	logic [ROOT_BITS-1:0] root;
	logic             accept;
	logic             ld_level;

	// the user has configuration written only while idle; unenforced, so take every request
	assign cfg_ready = 1'b1;

	ewt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.coef     (coef)
	);

	ewt_mul u_mul (
		.clk    (clk),
		.ctl    (mul_ctl),
		.mag    (mag_q),
		.coef   (coef_q),
		.diff   (diff_q),
		.prod_q (prod_q)
	);

	ewt_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (RAD_BITS'(y_q)),
		.root     (root),
		.stat     (root_stat)
	);

	// Magnitude of the sample; full-scale negative maps to 2^(N-1)
	assign raw   = sample[SAMPLE_BITS-1:0];
	assign mag_c = raw[SAMPLE_BITS-1] ? SAMPLE_BITS'(~raw + 1'b1) : raw;

	// Square moved up to the mean-square format
	assign v_c = MS_BITS'(prod_q[SQ_BITS-1:0]) << MS_FRAC_BITS;

	// High partial product aligned to the coefficient point
	assign hi_term = ACC_BITS'(prod_q) << (HALF_BITS - COEF_FRAC_BITS);

	assign accept = in_valid && in_ready;

	// Sequencer: next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:    if (in_valid) state_n = ST_SQUARE;
			ST_SQUARE:  state_n = ST_DIFF;
			ST_DIFF:    state_n = seed_q ? ST_ROOT_GO : ST_MUL_LO;
			ST_MUL_LO:  state_n = ST_MUL_HI;
			ST_MUL_HI:  state_n = ST_ADD;
			ST_ADD:     state_n = ST_ROOT_GO;
			ST_ROOT_GO: state_n = ST_ROOT;
			ST_ROOT:    if (root_stat.done) state_n = ST_OUT;
			ST_OUT:     if (!out_valid_q || out_ready) state_n = ST_IDLE;
			default:    state_n = ST_IDLE;
		endcase
	end

	// Sequencer: outputs
	always_comb begin
		in_ready    = 1'b0;
		mul_ctl     = '{en: 1'b0, sel: MUL_SQUARE};
		root_start  = 1'b0;
		ld_level    = 1'b0;
		case (state_q)
			ST_IDLE:    in_ready = 1'b1;
			ST_SQUARE:  mul_ctl = '{en: 1'b1, sel: MUL_SQUARE};
			ST_MUL_LO:  mul_ctl = '{en: 1'b1, sel: MUL_DIFF_LO};
			ST_MUL_HI:  mul_ctl = '{en: 1'b1, sel: MUL_DIFF_HI};
			ST_ROOT_GO: root_start = 1'b1;
			ST_OUT:     ld_level = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seeded_q    <= 1'b0;
			out_valid_q <= 1'b0;
			y_q         <= '0;
		end else begin
			state_q <= state_n;
			if (accept) begin
				seeded_q <= 1'b1;
			end
			// Seed on the first sample, on restart, and when a = 0 (no smoothing)
			if (state_q == ST_DIFF && seed_q) begin
				y_q <= v_c;
			end else if (state_q == ST_ADD) begin
				y_q <= MS_BITS'(acc_q + hi_term);
			end
			if (ld_level) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_q  <= mag_c;
			coef_q <= coef;
			seed_q <= restart || !seeded_q || (coef == '0);
		end
		if (state_q == ST_DIFF) begin
			v_q    <= v_c;
			diff_q <= ACC_BITS'(y_q) - ACC_BITS'(v_c);
		end
		// prod_q holds the low partial product during this state
		if (state_q == ST_MUL_HI) begin
			acc_q <= ACC_BITS'(v_q) + ACC_BITS'(prod_q[HALF_BITS*2-1:COEF_FRAC_BITS]);
		end
		if (ld_level) begin
			level_q <= root;
		end
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;

`ifndef SYNTHESIS
	a_start_idle_root: assert property (@(posedge clk) disable iff (!arst_n)
		root_start |-> !root_stat.busy)
		else $error("square root started while busy");

	a_done_in_root: assert property (@(posedge clk) disable iff (!arst_n)
		root_stat.done |-> (state_q == ST_ROOT))
		else $error("square root finished outside the wait state");

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready && (state_q == ST_SQUARE))
		else $error("request taken while a sample is in work");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ld_level |-> (!out_valid_q || out_ready))
		else $error("level register overwritten before it was taken");
`endif

endmodule

[rtl/core/ewt_cfg.sv]
// ----------------------------------------------------------------------------
// ewt_cfg: configuration registers
// Holds the weighting mode and the three decay factors and presents the
// factor that the current mode selects.
// ----------------------------------------------------------------------------
module ewt_cfg
	import ewt_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [CFG_IDX_BITS-1:0]   wr_index,
	input  logic [CFG_DATA_BITS-1:0]  wr_data,
	output logic [COEF_FRAC_BITS-1:0] coef
);

	logic [MODE_BITS-1:0]      mode_q;
	logic [COEF_FRAC_BITS-1:0] fast_q;
	logic [COEF_FRAC_BITS-1:0] slow_q;
	logic [COEF_FRAC_BITS-1:0] imp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FAST;
			fast_q <= COEF_FAST_RST;
			slow_q <= COEF_SLOW_RST;
			imp_q  <= COEF_IMPULSE_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_MODE:         mode_q <= wr_data[MODE_BITS-1:0];
				REG_COEF_FAST:    fast_q <= wr_data[COEF_FRAC_BITS-1:0];
				REG_COEF_SLOW:    slow_q <= wr_data[COEF_FRAC_BITS-1:0];
				REG_COEF_IMPULSE: imp_q  <= wr_data[COEF_FRAC_BITS-1:0];
				default: ;
			endcase
		end
	end

	// unused mode code falls back to fast
	always_comb begin
		case (mode_t'(mode_q))
			MODE_SLOW:    coef = slow_q;
			MODE_IMPULSE: coef = imp_q;
			default:      coef = fast_q;
		endcase
	end

endmodule

[rtl/core/ewt_mul.sv]
// ----------------------------------------------------------------------------
// ewt_mul: shared signed multiplier
// Picks its operands for the square or for one half of the smoothing
// product and registers the full product.
// ----------------------------------------------------------------------------
module ewt_mul
	import ewt_pkg::*;
(
	input  logic                        clk,
	input  mul_ctl_t                    ctl,
	input  logic [SAMPLE_BITS-1:0]      mag,
	input  logic [COEF_FRAC_BITS-1:0]   coef,
	input  logic [ACC_BITS-1:0]         diff,
	output logic signed [PROD_BITS-1:0] prod_q
);

	logic signed [MUL_OP_BITS-1:0] opa;
	logic signed [MUL_OP_BITS-1:0] opb;

	always_comb begin
		case (ctl.sel)
			MUL_SQUARE: begin
				opa = MUL_OP_BITS'(mag);
				opb = MUL_OP_BITS'(mag);
			end
			MUL_DIFF_LO: begin
				opa = MUL_OP_BITS'(coef);
				opb = MUL_OP_BITS'(diff[HALF_BITS-1:0]);
			end
			MUL_DIFF_HI: begin
				opa = MUL_OP_BITS'(coef);
				opb = MUL_OP_BITS'($signed(diff[ACC_BITS-1:HALF_BITS]));
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			prod_q <= opa * opb;
		end
	end

endmodule

[rtl/core/ewt_sqrt.sv]
// ----------------------------------------------------------------------------
// ewt_sqrt: bit-serial integer square root
// Restoring method, one root bit per cycle; the root holds until the next
// start.
// ----------------------------------------------------------------------------
module ewt_sqrt
	import ewt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [RAD_BITS-1:0]  radicand,
	output logic [ROOT_BITS-1:0] root,
	output root_stat_t           stat
);

	logic [RAD_BITS-1:0]  rad_q;
	logic [REM_BITS-1:0]  rem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [STEP_BITS-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [REM_BITS+1:0]  rem_sh;
	logic [REM_BITS+1:0]  trial;
	logic                 fits;

	assign rem_sh = {rem_q, rad_q[RAD_BITS-1 -: 2]};
	assign trial  = (REM_BITS+2)'({root_q, 2'b01});
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_BITS'(ROOT_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (fits) begin
				rem_q  <= REM_BITS'(rem_sh - trial);
				root_q <= {root_q[ROOT_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= REM_BITS'(rem_sh);
				root_q <= {root_q[ROOT_BITS-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
	assign stat = '{busy: busy_q, done: done_q};

endmodule
